/* rtl/arrs_pkg.sv */
// ----------------------------------------------------------------------------
// arrs_pkg
// Shared types, codes and constants for the aligned region read splitter.
// ----------------------------------------------------------------------------
package arrs_pkg;

	// Default table depth
	localparam int MAX_REGIONS_DEF = 16;
	// Segments emitted per read, at most
	localparam int MAX_RESULTS     = 16;
	// Entries in the command queue between front and back
	localparam int CMD_QUEUE_DEPTH = 2;

	localparam logic [4:0] BLOCK_SHIFT_RST = 5'd9;
	localparam logic [30:0] LEN31_MAX      = 31'h7FFF_FFFF;

	// Operation codes
	localparam logic OP_ADD  = 1'b0;
	localparam logic OP_READ = 1'b1;

	// Result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_OVF   = 2'd3;

	// Decoded command: arg is the aligned length (add) or the offset (read)
	typedef struct packed {
		logic        op;
		logic [32:0] arg;
		logic [30:0] len;
	} cmd_t;

	// One result item
	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  region_index;
		logic [31:0] offset_in_region;
		logic [30:0] segment_length;
		logic [31:0] total_length;
		logic        last;
	} res_t;

endpackage

/* rtl/arrs_ram.sv */
// ----------------------------------------------------------------------------
// arrs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module arrs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		// read data holds while re is low
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/arrs_front.sv */
// ----------------------------------------------------------------------------
// arrs_front
// Input side: holds block_shift, aligns add lengths, pushes decoded commands.
// ----------------------------------------------------------------------------
module arrs_front import arrs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  block_shift,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        operation,
	input  logic [31:0] source_length,
	input  logic [31:0] read_offset,
	input  logic [30:0] read_length,
	input  logic        q_full,
	output logic        q_push,
	output cmd_t        q_cmd
);

	logic [4:0]  block_shift_q;
	logic [32:0] mask;
	logic [32:0] aligned;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_shift_q <= BLOCK_SHIFT_RST;
		end else if (cfg_valid) begin
			block_shift_q <= block_shift;
		end
	end

	assign cfg_ready = 1'b1;

	// round up to 2^block_shift; 33 bits since the result may reach 2^32
	assign mask    = (33'd1 << block_shift_q) - 33'd1;
	assign aligned = ({1'b0, source_length} + mask) & ~mask;

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	always_comb begin
		q_cmd.op  = operation;
		q_cmd.arg = (operation == OP_ADD) ? aligned : {1'b0, read_offset};
		q_cmd.len = read_length;
	end

endmodule

/* rtl/arrs_queue.sv */
// ----------------------------------------------------------------------------
// arrs_queue
// Small command FIFO between the front and back parts.
// ----------------------------------------------------------------------------
module arrs_queue import arrs_pkg::*; #(
	parameter int DEPTH = CMD_QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	output logic not_empty,
	input  logic pop,
	output cmd_t pop_cmd
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          entry_q [DEPTH];
	logic [PW-1:0] wptr_q;
	logic [PW-1:0] rptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_cmd   = entry_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wptr_q] <= push_cmd;
		end
	end

endmodule

/* rtl/arrs_back.sv */
// ----------------------------------------------------------------------------
// arrs_back
// Execution side: region table, add/reject, read scan and segment emit.
// ----------------------------------------------------------------------------
module arrs_back import arrs_pkg::*; #(
	parameter int MAX_REGIONS = MAX_REGIONS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	input  cmd_t q_cmd,
	output logic q_pop,
	output logic res_valid,
	input  logic res_ready,
	output res_t res
);

	localparam int AW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
	localparam int CW = $clog2(MAX_REGIONS + 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_EXEC  = 3'd1;
	localparam logic [2:0] S_FETCH = 3'd2;
	localparam logic [2:0] S_CHK   = 3'd3;
	localparam logic [2:0] S_SEG   = 3'd4;

	logic [2:0]    state_q;
	cmd_t          cmd_q;
	logic [CW-1:0] count_q;
	logic [31:0]   space_end_q;
	logic [AW-1:0] idx_q;
	logic [3:0]    k_q;
	logic          run_q;
	logic [31:0]   off_q;
	logic [30:0]   len_q;
	logic [31:0]   d_q;
	logic          res_valid_q;
	res_t          res_q;

	logic          out_free;
	logic          emit;
	res_t          res_d;

	// add path
	logic [33:0]   add_sum;
	logic          tbl_full;
	logic          add_ovf;
	logic          add_ok;
	logic [30:0]   add_len_sat;
	logic          ram_we;

	// read setup
	logic [31:0]   rem;
	logic          rd_empty;
	logic [30:0]   len_clamp;

	// scan
	logic          ram_re;
	logic [63:0]   ram_rdata;
	logic [31:0]   rd_start;
	logic [31:0]   rd_alen;
	logic [31:0]   d_calc;
	logic          hit;
	logic [31:0]   avail;
	logic [32:0]   diff;
	logic          fin_len;
	logic          fin;
	logic [30:0]   seg_len;

	arrs_ram #(
		.WIDTH (64),
		.DEPTH (MAX_REGIONS)
	) u_tbl (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[AW-1:0]),
		.wdata ({space_end_q, cmd_q.arg[31:0]}),
		.re    (ram_re),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	assign rd_start = ram_rdata[63:32];
	assign rd_alen  = ram_rdata[31:0];

	assign out_free = !res_valid_q || res_ready;
	assign q_pop    = (state_q == S_IDLE) && q_valid;
	assign ram_re   = (state_q == S_FETCH);

	// add: reject on full table or 32-bit overflow of the total
	assign add_sum     = {2'b00, space_end_q} + {1'b0, cmd_q.arg};
	assign tbl_full    = (count_q >= CW'(MAX_REGIONS));
	assign add_ovf     = |add_sum[33:32];
	assign add_ok      = !tbl_full && !add_ovf;
	assign add_len_sat = (|cmd_q.arg[32:31]) ? LEN31_MAX : cmd_q.arg[30:0];
	assign ram_we      = (state_q == S_EXEC) && out_free && (cmd_q.op == OP_ADD) && add_ok;

	// read: clamp to the total
	assign rem       = space_end_q - cmd_q.arg[31:0];
	assign rd_empty  = (cmd_q.arg[31:0] >= space_end_q) || (cmd_q.len == '0);
	assign len_clamp = ({1'b0, cmd_q.len} > rem) ? rem[30:0] : cmd_q.len;

	// once a run starts, the next non-empty region begins exactly at the offset
	assign d_calc = off_q - rd_start;
	assign hit    = run_q ? (rd_alen != '0)
	                      : ((rd_start <= off_q) && (d_calc < rd_alen));

	// segment: cut at region end or at remaining length
	assign avail   = rd_alen - d_q;
	assign diff    = {2'b00, len_q} - {1'b0, avail};
	assign fin_len = diff[32] || (diff[31:0] == '0);
	assign fin     = fin_len || (k_q == 4'(MAX_RESULTS - 1));
	assign seg_len = fin_len ? len_q : avail[30:0];

	always_comb begin
		emit  = 1'b0;
		res_d = '0;
		res_d.total_length = space_end_q;
		res_d.last         = 1'b1;
		case (state_q)
			S_EXEC: begin
				if (out_free) begin
					if (cmd_q.op == OP_ADD) begin
						emit = 1'b1;
						if (tbl_full) begin
							res_d.status = ST_FULL;
						end else if (add_ovf) begin
							res_d.status = ST_OVF;
						end else begin
							res_d.status         = ST_OK;
							res_d.region_index   = 4'(count_q);
							res_d.segment_length = add_len_sat;
							res_d.total_length   = add_sum[31:0];
						end
					end else if (rd_empty) begin
						emit         = 1'b1;
						res_d.status = ST_EMPTY;
					end
				end
			end
			S_SEG: begin
				if (out_free) begin
					emit                   = 1'b1;
					res_d.status           = ST_OK;
					res_d.region_index     = 4'(idx_q);
					res_d.offset_in_region = d_q;
					res_d.segment_length   = seg_len;
					res_d.last             = fin;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			space_end_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (out_free) begin
						if (cmd_q.op == OP_ADD) begin
							if (add_ok) begin
								count_q     <= count_q + 1'b1;
								space_end_q <= add_sum[31:0];
							end
							state_q <= S_IDLE;
						end else if (rd_empty) begin
							state_q <= S_IDLE;
						end else begin
							state_q <= S_FETCH;
						end
					end
				end
				S_FETCH: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					state_q <= hit ? S_SEG : S_FETCH;
				end
				S_SEG: begin
					if (out_free) begin
						state_q <= fin ? S_IDLE : S_FETCH;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_cmd;
		end
		if (emit) begin
			res_q <= res_d;
		end
		case (state_q)
			S_EXEC: begin
				off_q <= cmd_q.arg[31:0];
				len_q <= len_clamp;
				idx_q <= '0;
				k_q   <= '0;
				run_q <= 1'b0;
			end
			S_CHK: begin
				if (hit) begin
					d_q <= run_q ? '0 : d_calc;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
			S_SEG: begin
				if (out_free && !fin) begin
					len_q <= diff[30:0];
					k_q   <= k_q + 1'b1;
					idx_q <= idx_q + 1'b1;
					run_q <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

/* rtl/aligned_region_read_splitter_top.sv */
// ----------------------------------------------------------------------------
// aligned_region_read_splitter_top
// Region table with aligned append and read-to-segment splitting.
// ----------------------------------------------------------------------------
// Regions are appended end to end in one 32-bit space, each rounded up to
// 2^block_shift bytes (block_shift resets to 9; write it only while idle).
// An add item returns one result: the assigned index, the aligned length
// (saturated to 31 bits) and the new total, or status table-full/overflow
// with the table unchanged. A read item is clamped to the total and split
// into one segment per non-empty region crossed, at most 16, the final one
// marked last; an offset at or past the total or a zero length gives one
// empty-status result. Flow: the front takes an item whenever the queue is
// not full and pushes it into a two-entry command queue, so up to two items
// are taken while the back is busy. In the back an add or an empty read
// passes the idle and exec states; a non-empty read then visits regions in
// turn, each region visit being a fetch and a check because the table sits
// in a RAM with registered read, and each segment adds a seg state.
// One result register drives the output; while it holds a result that
// out_ready has not taken, the back stalls at its next emit.
// No clearing pass after reset: only entries below the region count are
// ever read.
// ----------------------------------------------------------------------------
module aligned_region_read_splitter_top import arrs_pkg::*; #(
	parameter int MAX_REGIONS = MAX_REGIONS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  block_shift,
	// input items
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        operation,
	input  logic [31:0] source_length,
	input  logic [31:0] read_offset,
	input  logic [30:0] read_length,
	// result items
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [3:0]  region_index,
	output logic [31:0] offset_in_region,
	output logic [30:0] segment_length,
	output logic [31:0] total_length,
	output logic        last
);

	logic q_full;
	logic q_push;
	cmd_t q_push_cmd;
	logic q_not_empty;
	logic q_pop;
	cmd_t q_pop_cmd;
	res_t res;

	// front: config register, alignment, classification
	arrs_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.block_shift   (block_shift),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.operation     (operation),
		.source_length (source_length),
		.read_offset   (read_offset),
		.read_length   (read_length),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_cmd         (q_push_cmd)
	);

	// decouples the two sides
	arrs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (q_push_cmd),
		.full      (q_full),
		.not_empty (q_not_empty),
		.pop       (q_pop),
		.pop_cmd   (q_pop_cmd)
	);

	// back: table state, scan, result register
	arrs_back #(
		.MAX_REGIONS (MAX_REGIONS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_not_empty),
		.q_cmd     (q_pop_cmd),
		.q_pop     (q_pop),
		.res_valid (out_valid),
		.res_ready (out_ready),
		.res       (res)
	);

	assign status           = res.status;
	assign region_index     = res.region_index;
	assign offset_in_region = res.offset_in_region;
	assign segment_length   = res.segment_length;
	assign total_length     = res.total_length;
	assign last             = res.last;

endmodule

/* rtl/arrs_checker.sv */
// ----------------------------------------------------------------------------
// arrs_checker
// Port-level checks on the splitter's result stream.
// ----------------------------------------------------------------------------
module arrs_checker import arrs_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  status,
	input logic [3:0]  region_index,
	input logic [31:0] offset_in_region,
	input logic [30:0] segment_length,
	input logic [31:0] total_length,
	input logic        last
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(last)
			&& $stable(segment_length) && $stable(total_length))
		else $error("result changed while stalled");

	// rejects and empty reads are single results with zero index, offset and length
	a_non_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> last && region_index == '0
			&& offset_in_region == '0 && segment_length == '0)
		else $error("non-ok result malformed");

	// a non-final segment carries data
	a_mid_seg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> status == ST_OK && segment_length != '0)
		else $error("bad non-final segment");

	// segments of one read keep the same total
	a_total_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> !out_valid
			|| total_length == $past(total_length))
		else $error("total changed inside a read");

endmodule

bind aligned_region_read_splitter_top arrs_checker u_arrs_checker (.*);
